[sv/fod_pkg.sv]
// ----------------------------------------------------------------------------
// fod_pkg: shared types and constants of the flow spec operator decoder
// Command codes on the queue between front and back, status codes, limits.
// ----------------------------------------------------------------------------
package fod_pkg;

    // Terms stored per component
    localparam int TERM_LIMIT = 8;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Command codes carried through the queue
    localparam logic [1:0] CMD_OPER  = 2'd0;  // operator byte of a new term
    localparam logic [1:0] CMD_VALUE = 2'd1;  // inner value byte
    localparam logic [1:0] CMD_FINAL = 2'd2;  // last value byte, emits a result

    // Status codes reported on the last term
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;

    // One classified byte handed from front to back
    typedef struct packed {
        logic [1:0] code;
        logic [7:0] data;
        logic       kind;        // bitmask list, meaningful on CMD_OPER
        logic [7:0] term_index;  // the rest is meaningful on CMD_FINAL
        logic       stored;
        logic       last;
        logic [1:0] status;
        logic [7:0] term_count;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [7:0]  term_count;
        logic [1:0]  status;
        logic        stored;
        logic [7:0]  term_index;
        logic        and_op;
        logic        exact_match;
        logic        equal_to;
        logic        greater_than;
        logic        less_than;
        logic [31:0] value;
    } t_result;

endpackage

[sv/fod_front.sv]
// ----------------------------------------------------------------------------
// fod_front: byte classifier of the flow spec operator decoder
// Tracks the component position, counts available bytes and terms, builds
// the status, and pushes one command per useful byte into the queue.
// ----------------------------------------------------------------------------
module fod_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_start_req,
    input  logic          i_bitmask_kind,
    input  logic [11:0]   i_avail_bytes,
    input  logic          i_queue_full,
    output logic          o_push,
    output fod_pkg::t_cmd o_cmd
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_OPER  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    logic [1:0]  r_phase,  n_phase;
    logic [3:0]  r_vbl,    n_vbl;
    logic [11:0] r_avail,  n_avail;
    logic [7:0]  r_tc,     n_tc;
    logic [1:0]  r_st,     n_st;
    logic        r_kind,   n_kind;
    logic        r_end,    n_end;

    logic accept;
    logic do_oper;
    logic do_value;
    logic more;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    // Classify the byte and advance the component state
    always_comb begin
        n_phase  = r_phase;
        n_vbl    = r_vbl;
        n_avail  = r_avail;
        n_tc     = r_tc;
        n_st     = r_st;
        n_kind   = r_kind;
        n_end    = r_end;
        do_oper  = 1'b0;
        do_value = 1'b0;
        more     = 1'b0;
        o_push   = 1'b0;
        o_cmd    = '0;

        if (accept) begin
            if (i_start_req) begin
                n_kind  = i_bitmask_kind;
                n_avail = i_avail_bytes;
                n_tc    = 8'd0;
                n_st    = fod_pkg::ST_OK;
                do_oper = 1'b1;
            end else if (r_phase == PH_OPER) begin
                do_oper = 1'b1;
            end else if (r_phase == PH_VALUE) begin
                do_value = 1'b1;
            end
        end

        // Operator byte: latch length and end bit, check operator rules
        if (do_oper) begin
            n_end = i_data_byte[7];
            n_vbl = 4'd1 << i_data_byte[5:4];
            if (n_tc >= 8'(fod_pkg::TERM_LIMIT)) begin
                n_st = fod_pkg::ST_TOO_MANY;
            end
            if (!n_kind && i_data_byte[2] && i_data_byte[1]) begin
                n_st = fod_pkg::ST_MALFORMED;
            end
            if (i_data_byte[6] && (n_tc == 8'd0)) begin
                n_st = fod_pkg::ST_MALFORMED;
            end
            if (n_avail == 12'd0) begin
                n_st = fod_pkg::ST_MALFORMED;
            end else begin
                n_avail = n_avail - 12'd1;
            end
            n_phase    = PH_VALUE;
            o_push     = 1'b1;
            o_cmd.code = fod_pkg::CMD_OPER;
            o_cmd.data = i_data_byte;
            o_cmd.kind = n_kind;
        end

        // Value byte: count down, close the term on the last one
        if (do_value) begin
            if (n_avail == 12'd0) begin
                n_st = fod_pkg::ST_MALFORMED;
            end else begin
                n_avail = n_avail - 12'd1;
            end
            if (n_vbl != 4'd0) begin
                n_vbl = n_vbl - 4'd1;
            end
            o_push     = 1'b1;
            o_cmd.code = fod_pkg::CMD_VALUE;
            o_cmd.data = i_data_byte;
            if (n_vbl == 4'd0) begin
                more = !r_end && (n_avail >= 12'd2);
                if (more && r_kind &&
                    (({1'b0, r_tc} + 9'd1) >= 9'(fod_pkg::TERM_LIMIT))) begin
                    more = 1'b0;
                    n_st = fod_pkg::ST_TOO_MANY;
                end
                o_cmd.code       = fod_pkg::CMD_FINAL;
                o_cmd.term_index = r_tc;
                o_cmd.stored     = r_tc < 8'(fod_pkg::TERM_LIMIT);
                o_cmd.last       = !more;
                if (more) begin
                    if (r_tc != 8'hFF) begin
                        n_tc = r_tc + 8'd1;
                    end
                    n_phase = PH_OPER;
                end else begin
                    o_cmd.status = n_st;
                    if (n_st == fod_pkg::ST_OK) begin
                        o_cmd.term_count = r_tc + 8'd1;
                    end
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_vbl   <= 4'd0;
            r_avail <= 12'd0;
            r_tc    <= 8'd0;
            r_st    <= fod_pkg::ST_OK;
            r_kind  <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_vbl   <= n_vbl;
            r_avail <= n_avail;
            r_tc    <= n_tc;
            r_st    <= n_st;
            r_kind  <= n_kind;
            r_end   <= n_end;
        end
    end

endmodule

[sv/fod_queue.sv]
// ----------------------------------------------------------------------------
// fod_queue: short command queue between front and back
// First-in first-out buffer of classified bytes; head is read in place.
// ----------------------------------------------------------------------------
module fod_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fod_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output fod_pkg::t_cmd o_head
);

    fod_pkg::t_cmd r_mem [fod_pkg::QUEUE_DEPTH];

    logic [fod_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [fod_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [fod_pkg::QUEUE_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full       = r_count == (fod_pkg::QUEUE_AW + 1)'(fod_pkg::QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    // Store the incoming command
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/fod_back.sv]
// ----------------------------------------------------------------------------
// fod_back: term assembler of the flow spec operator decoder
// Holds the current operator, shifts in value bytes and formats one result
// into the output register when a term closes.
// ----------------------------------------------------------------------------
module fod_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  fod_pkg::t_cmd    i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output fod_pkg::t_result o_result,
    output logic             o_last
);

    logic [7:0]  r_op;
    logic        r_kind;
    logic [31:0] r_acc;
    logic        r_out_valid;
    fod_pkg::t_result r_result, n_result;
    logic        r_last;

    logic        out_free;
    logic        is_final;
    logic [31:0] n_acc;

    assign out_free = !r_out_valid || i_ready;
    assign is_final = i_head.code == fod_pkg::CMD_FINAL;
    assign o_pop    = i_head_valid && (!is_final || out_free);
    assign n_acc    = {r_acc[23:0], i_head.data};

    // Translate operator bits into the result fields
    always_comb begin
        n_result            = '0;
        n_result.value      = n_acc;
        n_result.and_op     = r_op[6];
        n_result.term_index = i_head.term_index;
        n_result.stored     = i_head.stored;
        n_result.status     = i_head.status;
        n_result.term_count = i_head.term_count;
        if (r_kind) begin
            n_result.less_than    = r_op[1];
            n_result.greater_than = r_op[1];
            n_result.equal_to     = !r_op[1];
            n_result.exact_match  = r_op[0];
        end else begin
            n_result.less_than    = r_op[2];
            n_result.greater_than = r_op[1];
            n_result.equal_to     = r_op[0];
            n_result.exact_match  = 1'b0;
        end
    end

    // Hold operator and value accumulator
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_head.code)
                fod_pkg::CMD_OPER: begin
                    r_op   <= i_head.data;
                    r_kind <= i_head.kind;
                    r_acc  <= 32'd0;
                end
                fod_pkg::CMD_VALUE, fod_pkg::CMD_FINAL: begin
                    r_acc <= n_acc;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    // Load the output register on a closing byte
    always_ff @(posedge i_clk) begin
        if (o_pop && is_final) begin
            r_result <= n_result;
            r_last   <= i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && is_final) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

endmodule

[sv/flowspec_operator_decoder_core.sv]
// ----------------------------------------------------------------------------
// flowspec_operator_decoder_core: flow spec numeric/bitmask operator decoder
// Decodes operator/value terms of one component body and emits one result
// per term, with status and term count on the last one.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  s_axis  | in  | one body byte per request; tdata byte, avail; tuser start, kind
//  m_axis  | out | one decoded term per request; tlast on the final term
//
//  One byte per cycle while the command queue is not full; the last value byte of a
//  term is registered in the command queue, its result then in the output register.
//  The front stalls only when the four-entry command queue is full; the back
//  stalls only on a closing byte while the output register is still held.
//  Synchronous active-low reset returns the decoder to idle and empties queue
//  and output register.
// ----------------------------------------------------------------------------
module flowspec_operator_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] data_byte, [19:8] avail_bytes, zero pad
    input  logic [1:0]  i_s_axis_tuser,   // [0] start_req, [1] bitmask_kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] value, [32] less_than, [33] greater_than, [34] equal_to,
    // [35] exact_match, [36] and_op, [44:37] term_index, [45] stored,
    // [47:46] status, [55:48] term_count
    output logic [55:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic             queue_full;
    logic             push;
    fod_pkg::t_cmd    push_cmd;
    logic             pop;
    logic             head_valid;
    fod_pkg::t_cmd    head;
    fod_pkg::t_result result;

    fod_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_data_byte    (i_s_axis_tdata[7:0]),
        .i_start_req    (i_s_axis_tuser[0]),
        .i_bitmask_kind (i_s_axis_tuser[1]),
        .i_avail_bytes  (i_s_axis_tdata[19:8]),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    fod_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    fod_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_result     (result),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = result;

endmodule

[sv/fod_checker.sv]
// ----------------------------------------------------------------------------
// fod_checker: port-level checks of the flow spec operator decoder
// Checks results held while stalled and consistent status, count and stored.
// ----------------------------------------------------------------------------
module fod_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // Hold a stalled result request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // Keep status and count clear on inner terms
    a_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |->
            o_m_axis_tdata[47:46] == fod_pkg::ST_OK && o_m_axis_tdata[55:48] == 8'd0)
        else $error("status or count on an inner term");

    // Drop the count on a failed component, give one on a good one
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            (o_m_axis_tdata[47:46] != fod_pkg::ST_OK && o_m_axis_tdata[55:48] == 8'd0) ||
            (o_m_axis_tdata[47:46] == fod_pkg::ST_OK &&
             o_m_axis_tdata[55:48] == o_m_axis_tdata[44:37] + 8'd1))
        else $error("term count does not match status and index");

    // Flag storage exactly below the term limit
    a_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[45] == (o_m_axis_tdata[44:37] < 8'(fod_pkg::TERM_LIMIT)))
        else $error("stored flag disagrees with term index");

endmodule

bind flowspec_operator_decoder_core fod_checker u_fod_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[test/tb_flowspec_operator_decoder_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flowspec_operator_decoder_core: self-checking bench of the operator decoder
// Walks a short directed table of component bodies, then random components
// (well-formed lists, overruns, abandoned and noise bytes) through the byte
// stream. A local model of the decoder predicts every term and each returned
// term is compared field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_flowspec_operator_decoder_core;

    // Decoder phases of the local model
    typedef enum logic [1:0] {
        DEC_IDLE  = 2'd0,
        DEC_OPER  = 2'd1,
        DEC_VALUE = 2'd2
    } t_dec_phase;

    // Shapes of a generated component
    typedef enum int {
        SHAPE_EXACT,    // avail covers the body exactly
        SHAPE_LOOSE,    // avail random over the full range
        SHAPE_OVERRUN,  // avail shorter than the body
        SHAPE_CUT,      // body broken off, next start abandons it
        SHAPE_FULL      // avail at its maximum
    } t_comp_shape;

    // One expected term
    typedef struct packed {
        logic             last;
        fod_pkg::t_result r;
    } t_term_exp;

    // One row of the directed table; the expected term applies when chk is set
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        kind;
        logic [11:0] avail;
        logic        chk;
        logic [31:0] value;
        logic        lt;
        logic        gt;
        logic        eq;
        logic        em;
        logic        and_op;
        logic [7:0]  idx;
        logic        stored;
        logic [1:0]  status;
        logic [7:0]  cnt;
    } t_dir_row;

    localparam int DIR_ROWS = 26;

    // data, start, kind, avail, chk | value, lt, gt, eq, em, and, idx, stored, status, cnt
    t_dir_row dir_tbl [DIR_ROWS] = '{
        // byte while idle, ignored
        '{8'h5A, 1'b0, 1'b0, 12'hFFF, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        // component abandoned by the next start
        '{8'h10, 1'b1, 1'b0, 12'd3, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'h77, 1'b0, 1'b1, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        // single equal term, one-byte value at its maximum
        '{8'h81, 1'b1, 1'b0, 12'd2, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 12'd0, 1'b1, 32'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          8'd0, 1'b1, fod_pkg::ST_OK, 8'd1},
        // eight-byte value, low word kept
        '{8'hB4, 1'b1, 1'b0, 12'd9, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'h12, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'h34, 1'b0, 1'b1, 12'hFFF, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'h56, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'h78, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 12'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b1, fod_pkg::ST_OK, 8'd1},
        // less together with greater
        '{8'h86, 1'b1, 1'b0, 12'd2, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'h00, 1'b0, 1'b0, 12'd0, 1'b1, 32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b1, fod_pkg::ST_MALFORMED, 8'd0},
        // and bit on the first term
        '{8'hC1, 1'b1, 1'b0, 12'd2, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'h55, 1'b0, 1'b0, 12'd0, 1'b1, 32'h55, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
          8'd0, 1'b1, fod_pkg::ST_MALFORMED, 8'd0},
        // value running past the available bytes
        '{8'h91, 1'b1, 1'b0, 12'd1, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hAB, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hCD, 1'b0, 1'b0, 12'd0, 1'b1, 32'hABCD, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
          8'd0, 1'b1, fod_pkg::ST_MALFORMED, 8'd0},
        // two-term bitmask list: not with match, then and with match
        '{8'h13, 1'b1, 1'b1, 12'd6, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hF0, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'h0F, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hC1, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0},
        '{8'hAA, 1'b0, 1'b0, 12'd0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
          8'd0, 1'b0, fod_pkg::ST_OK, 8'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_tdata = '0;     // [7:0] data_byte, [19:8] avail_bytes, zero pad
    logic [1:0]  s_tuser = '0;     // [0] start_req, [1] bitmask_kind
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [55:0] m_tdata;          // value .. term_count, packed as t_result
    logic        m_tlast;

    // Bench state
    bit          jitter_on = 1'b1;
    bit          row_has_exp = 1'b0;
    t_term_exp   row_exp = '0;
    t_term_exp   pending_terms[$];
    int          err_cnt = 0;
    int          sent_items = 0;

    // Local model of the decoder
    t_dec_phase  dec_phase = DEC_IDLE;
    logic [7:0]  dec_oper = '0;
    logic [31:0] dec_acc = '0;
    logic [3:0]  dec_len_left = '0;
    logic [11:0] dec_avail = '0;
    int          dec_terms = 0;
    logic [1:0]  dec_status = fod_pkg::ST_OK;
    logic        dec_kind = 1'b0;

    flowspec_operator_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count one body byte against the available bytes
    function automatic void use_avail_byte();
        if (dec_avail == 0) begin
            dec_status = fod_pkg::ST_MALFORMED;
        end else begin
            dec_avail--;
        end
    endfunction

    // Latch an operator byte and open its value
    function automatic void latch_operator(input logic [7:0] b);
        dec_oper     = b;
        dec_acc      = '0;
        dec_len_left = 4'd1 << b[5:4];
        if (dec_terms >= fod_pkg::TERM_LIMIT) dec_status = fod_pkg::ST_TOO_MANY;
        if (!dec_kind && b[2] && b[1]) dec_status = fod_pkg::ST_MALFORMED;
        if (b[6] && dec_terms == 0) dec_status = fod_pkg::ST_MALFORMED;
        use_avail_byte();
        dec_phase = DEC_VALUE;
    endfunction

    // Advance the model by one accepted byte; return 1 with the term it closes
    function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                       input logic kind, input logic [11:0] avail,
                                       output t_term_exp res);
        bit more;
        res = '0;
        if (start) begin
            dec_kind   = kind;
            dec_avail  = avail;
            dec_terms  = 0;
            dec_status = fod_pkg::ST_OK;
            latch_operator(b);
            return 1'b0;
        end
        if (dec_phase == DEC_OPER) begin
            latch_operator(b);
            return 1'b0;
        end
        if (dec_phase != DEC_VALUE) return 1'b0;

        dec_acc = {dec_acc[23:0], b};
        use_avail_byte();
        if (dec_len_left != 0) dec_len_left--;
        if (dec_len_left != 0) return 1'b0;

        // Close the term: keep going only with no end bit and room for another
        more = !dec_oper[7] && dec_avail >= 2;
        if (more && dec_kind && dec_terms + 1 >= fod_pkg::TERM_LIMIT) begin
            more       = 1'b0;
            dec_status = fod_pkg::ST_TOO_MANY;
        end
        res.r.value = dec_acc;
        if (dec_kind) begin
            res.r.less_than    = dec_oper[1];
            res.r.greater_than = dec_oper[1];
            res.r.equal_to     = !dec_oper[1];
            res.r.exact_match  = dec_oper[0];
        end else begin
            res.r.less_than    = dec_oper[2];
            res.r.greater_than = dec_oper[1];
            res.r.equal_to     = dec_oper[0];
            res.r.exact_match  = 1'b0;
        end
        res.r.and_op     = dec_oper[6];
        res.r.term_index = 8'(dec_terms);
        res.r.stored     = dec_terms < fod_pkg::TERM_LIMIT;
        if (more) begin
            if (dec_terms < 255) dec_terms++;
            dec_phase = DEC_OPER;
        end else begin
            res.last         = 1'b1;
            res.r.status     = dec_status;
            res.r.term_count = (dec_status == fod_pkg::ST_OK) ? 8'(dec_terms + 1) : 8'd0;
            dec_phase        = DEC_IDLE;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // Random operator byte; plain keeps it clear of the malformed cases
    function automatic logic [7:0] make_op(input bit kind, input bit first,
                                           input bit closing, input bit plain,
                                           input bit short_val);
        logic [7:0] op;
        op = 8'($urandom);
        if (closing) op[7] = plain ? 1'b1 : 1'($urandom);
        else op[7] = !plain && $urandom_range(0, 19) == 0;
        if (first) op[6] = !plain && $urandom_range(0, 9) == 0;
        if (!kind && op[2] && op[1] && (plain || $urandom_range(0, 2) != 0)) op[1] = 1'b0;
        if (short_val) op[5:4] = 2'd0;
        return op;
    endfunction

    // Drive one request and hold it until it is taken
    task automatic send_byte(input logic [7:0] b, input logic start, input logic kind,
                             input logic [11:0] avail, input bit has_exp = 1'b0,
                             input t_term_exp want = '0);
        while (jitter_on && $urandom_range(0, 99) < 14) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        s_valid     = 1'b1;
        s_tdata     = {4'h0, avail, b};
        s_tuser     = {kind, start};
        row_has_exp = has_exp;
        row_exp     = want;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Build one component body and stream it
    task automatic send_component(input bit kind, input int nterms, input t_comp_shape shape,
                                  input bit plain, input bit short_val);
        logic [7:0]  body[$];
        logic [7:0]  op;
        logic [11:0] avail;
        int          keep;
        for (int i = 0; i < nterms; i++) begin
            op = make_op(kind, i == 0, i == nterms - 1, plain,
                         short_val || $urandom_range(0, 2) == 0);
            body.push_back(op);
            repeat (1 << op[5:4]) body.push_back(8'($urandom));
        end
        case (shape)
            SHAPE_LOOSE:   avail = 12'($urandom);
            SHAPE_OVERRUN: avail = 12'($urandom_range(0, body.size() - 1));
            SHAPE_FULL:    avail = 12'hFFF;
            default:       avail = 12'(body.size());
        endcase
        if (shape == SHAPE_CUT) begin
            keep = $urandom_range(1, body.size() - 1);
            while (body.size() > keep) void'(body.pop_back());
        end
        send_byte(body[0], 1'b1, kind, avail);
        for (int i = 1; i < body.size(); i++) begin
            send_byte(body[i], 1'b0, 1'($urandom), 12'($urandom));
        end
        sent_items += body.size();
    endtask

    // Vary the result side ready
    always @(negedge i_clk) begin
        m_tready = !jitter_on || $urandom_range(0, 99) >= 14;
    end

    // Check returned terms, then advance the model on accepted requests
    always @(posedge i_clk) begin
        fod_pkg::t_result got;
        t_term_exp        want;
        t_term_exp        model_term;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = fod_pkg::t_result'(m_tdata);
                if (pending_terms.size() == 0) begin
                    $error("term with no expectation: value 0x%0h", got.value);
                    err_cnt++;
                end else begin
                    want = pending_terms.pop_front();
                    check_field("value", want.r.value, got.value);
                    check_field("less_than", want.r.less_than, got.less_than);
                    check_field("greater_than", want.r.greater_than, got.greater_than);
                    check_field("equal_to", want.r.equal_to, got.equal_to);
                    check_field("exact_match", want.r.exact_match, got.exact_match);
                    check_field("and_op", want.r.and_op, got.and_op);
                    check_field("term_index", want.r.term_index, got.term_index);
                    check_field("stored", want.r.stored, got.stored);
                    check_field("last", want.last, m_tlast);
                    check_field("status", want.r.status, got.status);
                    check_field("term_count", want.r.term_count, got.term_count);
                end
            end
            if (s_valid && s_tready) begin
                if (decode_byte(s_tdata[7:0], s_tuser[0], s_tuser[1], s_tdata[19:8],
                                model_term)) begin
                    pending_terms.push_back(row_has_exp ? row_exp : model_term);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_term_exp   want;
        t_dir_row    row;
        int          pick;
        int          n;
        bit          long_done;
        bit          kind;
        int          nterms;
        t_comp_shape shape;

        long_done = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        foreach (dir_tbl[i]) begin
            row                = dir_tbl[i];
            want               = '0;
            want.last          = 1'b1;
            want.r.value       = row.value;
            want.r.less_than   = row.lt;
            want.r.greater_than = row.gt;
            want.r.equal_to    = row.eq;
            want.r.exact_match = row.em;
            want.r.and_op      = row.and_op;
            want.r.term_index  = row.idx;
            want.r.stored      = row.stored;
            want.r.status      = row.status;
            want.r.term_count  = row.cnt;
            send_byte(row.data, row.start, row.kind, row.avail, row.chk, want);
        end
        sent_items = DIR_ROWS;

        // Random components, with one stretch of steady flow
        while (sent_items < 1050) begin
            jitter_on = !(sent_items >= 850 && sent_items < 1000);
            if (!long_done && sent_items >= 200) begin
                // long numeric list: index saturates, status too many
                send_component(1'b0, 258, SHAPE_FULL, 1'b1, 1'b1);
                long_done = 1'b1;
            end else begin
                pick   = $urandom_range(0, 99);
                kind   = 1'($urandom);
                nterms = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 12);
                if (pick < 60) begin
                    shape = ($urandom_range(0, 4) == 0) ? SHAPE_LOOSE : SHAPE_EXACT;
                    send_component(kind, nterms, shape, $urandom_range(0, 3) != 0,
                                   1'($urandom));
                end else if (pick < 72) begin
                    send_component(kind, nterms, SHAPE_OVERRUN, 1'($urandom), 1'($urandom));
                end else if (pick < 84) begin
                    send_component(kind, nterms, SHAPE_CUT, 1'($urandom), 1'($urandom));
                end else if (pick < 92) begin
                    // stray bytes with no start
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        send_byte(8'($urandom), 1'b0, 1'($urandom), 12'($urandom));
                    end
                    sent_items += n;
                end else begin
                    // raw noise, starts included
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom),
                                  12'($urandom));
                    end
                    sent_items += n;
                end
            end
        end
        s_valid   = 1'b0;
        jitter_on = 1'b1;

        // Drain outstanding terms, then watch for strays
        for (int k = 0; k < 5000 && pending_terms.size() != 0; k++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_terms.size() != 0) begin
            $error("%0d expected terms never returned", pending_terms.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
sv/fod_pkg.sv
sv/fod_front.sv
sv/fod_queue.sv
sv/fod_back.sv
sv/flowspec_operator_decoder_core.sv
sv/fod_checker.sv
test/tb_flowspec_operator_decoder_core.sv
